[rtl/quad_tag_pose_measure_core_defines.svh]
// Assertion macros for the tag pose core
`ifndef QUAD_TAG_POSE_MEASURE_CORE_DEFINES_SVH
`define QUAD_TAG_POSE_MEASURE_CORE_DEFINES_SVH
// implication checked every clock outside reset
`define QTPM_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("lbl failed");
// next-cycle implication
`define QTPM_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("lbl failed");
`endif

[rtl/qtpm_pkg.sv]
`timescale 1ns / 1ps
package qtpm_pkg;
    typedef struct packed {
        logic [15:0] tag_id;
        logic [1:0]  orientation;
        logic [15:0] corner0_x;
        logic [15:0] corner0_y;
        logic [15:0] corner1_x;
        logic [15:0] corner1_y;
        logic [15:0] corner2_x;
        logic [15:0] corner2_y;
        logic [15:0] corner3_x;
        logic [15:0] corner3_y;
    } t_in_word;

    typedef struct packed {
        logic [15:0]        tag_out;
        logic [1:0]         orientation_out;
        logic [17:0]        mid_x;
        logic [17:0]        mid_y;
        logic [16:0]        diagonal_len;
        logic signed [15:0] twist_angle;
    } t_out_word;

    // classified item handed from front to back
    typedef struct packed {
        logic [15:0]        tag;
        logic [1:0]         orient;
        logic [17:0]        cx;
        logic [17:0]        cy;
        logic signed [16:0] e01x;
        logic signed [16:0] e01y;
        logic signed [16:0] e32x;
        logic signed [16:0] e32y;
        logic signed [16:0] d02x;
        logic signed [16:0] d02y;
        logic signed [16:0] d13x;
        logic signed [16:0] d13y;
    } t_job;

    // fraction bits of the corners; diagonal_len keeps the input unit
    localparam int COORD_FRAC_BITS = 4;
    localparam int TABLE_LEN = 24;
    localparam int ZW = 34;
    localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
    localparam logic signed [15:0] PI_Q13 = 16'sd25736;

    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic [31:0] v;
        case (i)
            0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
            3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
            6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
            9: v = 32'h001FFFFD;  10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
            18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
            21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
            default: v = 32'h0;
        endcase
        return ZW'($signed({2'b00, v}));
    endfunction
endpackage

[rtl/quad_tag_pose_measure_core.sv]
`timescale 1ns / 1ps
// ANGLE_STEPS (default 16) is used up to 24, the length of the arctangent table.
// Throughput: one word per cycle when the output is not stalled; set by the pipelined CORDIC and root stages.
// A four-entry queue with a registered output decouples front and back.
// Reset (i_rst_n low, synchronous) empties all stages and the queue.
module quad_tag_pose_measure_core #(
    parameter int ANGLE_STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  qtpm_pkg::t_in_word  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output qtpm_pkg::t_out_word o_data
);
    import qtpm_pkg::*;

    logic f_valid, f_stall, q_valid, q_stall;
    t_job f_job, q_job;

    qtpm_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .o_valid(f_valid), .i_stall(f_stall), .o_job(f_job)
    );

    qtpm_fifo #(.DEPTH(4)) u_fifo (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_stall(f_stall), .i_data(f_job),
        .o_valid(q_valid), .i_stall(q_stall), .o_data(q_job)
    );

    qtpm_back #(.ANGLE_STEPS(ANGLE_STEPS)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_stall(q_stall), .i_job(q_job),
        .o_valid, .i_stall, .o_data
    );
endmodule

[rtl/qtpm_front.sv]
`timescale 1ns / 1ps
// Reorders the corners and forms sums and differences; one register stage.
module qtpm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  qtpm_pkg::t_in_word i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output qtpm_pkg::t_job    o_job
);
    import qtpm_pkg::*;

    logic [15:0] cx [4];
    logic [15:0] cy [4];
    logic [15:0] px [4];
    logic [15:0] py [4];
    logic [1:0]  sh;
    logic [1:0]  src;
    t_job        n_job;
    t_job        r_job;
    logic        r_valid;

    assign o_stall = r_valid && i_stall;

    always_comb begin
        cx[0] = i_data.corner0_x; cy[0] = i_data.corner0_y;
        cx[1] = i_data.corner1_x; cy[1] = i_data.corner1_y;
        cx[2] = i_data.corner2_x; cy[2] = i_data.corner2_y;
        cx[3] = i_data.corner3_x; cy[3] = i_data.corner3_y;
        unique case (i_data.orientation)
            2'd0:    sh = 2'd2;
            2'd1:    sh = 2'd1;
            2'd2:    sh = 2'd0;
            default: sh = 2'd3;
        endcase
        for (int k = 0; k < 4; k++) begin
            src = 2'(3 - k) + sh;
            px[k] = cx[src];
            py[k] = cy[src];
        end
        n_job.tag    = i_data.tag_id;
        n_job.orient = i_data.orientation;
        n_job.cx = 18'(px[0]) + 18'(px[1]) + 18'(px[2]) + 18'(px[3]);
        n_job.cy = 18'(py[0]) + 18'(py[1]) + 18'(py[2]) + 18'(py[3]);
        n_job.e01x = $signed({1'b0, px[0]}) - $signed({1'b0, px[1]});
        n_job.e01y = $signed({1'b0, py[0]}) - $signed({1'b0, py[1]});
        n_job.e32x = $signed({1'b0, px[3]}) - $signed({1'b0, px[2]});
        n_job.e32y = $signed({1'b0, py[3]}) - $signed({1'b0, py[2]});
        n_job.d02x = $signed({1'b0, px[0]}) - $signed({1'b0, px[2]});
        n_job.d02y = $signed({1'b0, py[0]}) - $signed({1'b0, py[2]});
        n_job.d13x = $signed({1'b0, px[1]}) - $signed({1'b0, px[3]});
        n_job.d13y = $signed({1'b0, py[1]}) - $signed({1'b0, py[3]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_job <= n_job;
        end
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;
endmodule

[rtl/qtpm_fifo.sv]
`timescale 1ns / 1ps
// Small queue between front and back, registered read into an output word.
module qtpm_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  qtpm_pkg::t_job i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output qtpm_pkg::t_job o_data
);
    import qtpm_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_job           r_mem [DEPTH];
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  r_rp;
    logic [AW:0]    r_cnt;
    t_job           r_data;
    logic           r_ov;
    logic           wr;
    logic           rd;
    logic           load;
    logic           byp;
    logic           push;

    assign o_valid = r_ov;
    assign o_data  = r_data;
    assign o_stall = r_cnt == (AW+1)'(DEPTH);
    assign wr   = i_valid && !o_stall;
    // output word is free or leaving this cycle
    assign load = !r_ov || !i_stall;
    assign rd   = load && r_cnt != '0;
    // empty store: word goes straight to the output
    assign byp  = wr && load && r_cnt == '0;
    assign push = wr && !byp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (push) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (rd) r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(rd);
            if (load) r_ov <= rd || byp;
        end
        if (push) r_mem[r_wp] <= i_data;
        if (rd) begin
            r_data <= r_mem[r_rp];
        end else if (byp) begin
            r_data <= i_data;
        end
    end
endmodule

[rtl/qtpm_back.sv]
`timescale 1ns / 1ps
// Pipelined CORDIC angles, square roots and combination.
module qtpm_back #(
    parameter int ANGLE_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  qtpm_pkg::t_job     i_job,
    output logic               o_valid,
    input  logic               i_stall,
    output qtpm_pkg::t_out_word o_data
);
    import qtpm_pkg::*;
    localparam int NS = (ANGLE_STEPS < TABLE_LEN) ? ANGLE_STEPS : TABLE_LEN;
    localparam int VW = 44; // 17 bit diff scaled 2^24 plus CORDIC growth
    localparam int RW = 19; // root of 38 bit radicand
    localparam int NR = 19;
    localparam int NST = (NS > NR) ? NS : NR;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cord;

    typedef struct packed {
        logic [2*RW-1:0] v;
        logic [RW-1:0]   r;
    } t_root;

    logic               adv;
    logic               r_v   [NST+3];
    logic [15:0]        r_tag [NST+3];
    logic [1:0]         r_or  [NST+3];
    logic [17:0]        r_cx  [NST+3];
    logic [17:0]        r_cy  [NST+3];
    t_cord              r_a   [NST+1];
    t_cord              r_b   [NST+1];
    t_root              r_p   [NST+1];
    t_root              r_q   [NST+1];
    logic signed [ZW-1:0] r_a01;
    logic signed [ZW+1:0] r_ch;
    logic signed [ZW-1:0] r_tw;
    logic [16:0]        r_dl, r_dl2;
    t_out_word          r_out;
    logic               r_ov;

    assign adv     = !(r_ov && i_stall);
    assign o_stall = !adv;

    function automatic t_cord cord_init(input logic signed [16:0] x,
                                        input logic signed [16:0] y);
        t_cord c;
        c.x = VW'(x) <<< 24;
        c.y = VW'(y) <<< 24;
        c.z = '0;
        if (x < 0) begin
            c.z = (y >= 0) ? PI_Q30 : -PI_Q30;
            c.x = -c.x;
            c.y = -c.y;
        end
        return c;
    endfunction

    function automatic t_cord cord_step(input t_cord c, input int i);
        t_cord n;
        n = c;
        if (i < NS) begin
            if (c.y > 0) begin
                n.x = c.x + (c.y >>> i);
                n.y = c.y - (c.x >>> i);
                n.z = c.z + atan_q30(i);
            end else begin
                n.x = c.x - (c.y >>> i);
                n.y = c.y + (c.x >>> i);
                n.z = c.z - atan_q30(i);
            end
        end
        return n;
    endfunction

    function automatic t_root sq_init(input logic signed [16:0] dx,
                                      input logic signed [16:0] dy);
        t_root s;
        logic [33:0] a;
        logic [33:0] b;
        a = 34'($signed(dx) * $signed(dx));
        b = 34'($signed(dy) * $signed(dy));
        s.v = ((2*RW)'(a) + (2*RW)'(b)) << 4;
        s.r = '0;
        return s;
    endfunction

    // one result bit per stage, restoring
    function automatic t_root sq_step(input t_root s, input int i);
        t_root n;
        logic [RW-1:0] t;
        logic [2*RW-1:0] t2;
        n = s;
        if (i < NR) begin
            t  = s.r | (RW'(1) << (NR - 1 - i));
            t2 = (2*RW)'(t) * (2*RW)'(t);
            if (t2 <= s.v) n.r = t;
        end
        return n;
    endfunction

    function automatic logic signed [ZW+1:0] wrapz(input logic signed [ZW+1:0] v);
        logic signed [ZW+1:0] w;
        w = v;
        if (w >= (ZW+2)'(PI_Q30)) w = w - 2 * (ZW+2)'(PI_Q30);
        else if (w < -(ZW+2)'(PI_Q30)) w = w + 2 * (ZW+2)'(PI_Q30);
        return w;
    endfunction

    function automatic logic signed [15:0] round13(input logic signed [ZW-1:0] t);
        logic signed [ZW:0] s;
        logic signed [17:0] q;
        s = ((ZW+1)'(t) + (ZW+1)'(65536)) >>> 17;
        q = 18'(s);
        if (q >= 18'(PI_Q13)) q = q - 18'(2 * PI_Q13);
        return 16'(q);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST+3; k++) r_v[k] <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < NST+3; k++) r_v[k] <= r_v[k-1];
            r_ov <= r_v[NST+2];
        end
        if (adv) begin
            r_tag[0] <= i_job.tag;
            r_or[0]  <= i_job.orient;
            r_cx[0]  <= i_job.cx;
            r_cy[0]  <= i_job.cy;
            r_a[0] <= (i_job.e01x == 0 && i_job.e01y == 0) ? t_cord'(0)
                     : cord_init(i_job.e01x, i_job.e01y);
            r_b[0] <= (i_job.e32x == 0 && i_job.e32y == 0) ? t_cord'(0)
                     : cord_init(i_job.e32x, i_job.e32y);
            r_p[0] <= sq_init(i_job.d02x, i_job.d02y);
            r_q[0] <= sq_init(i_job.d13x, i_job.d13y);
            for (int k = 1; k < NST+3; k++) begin
                r_tag[k] <= r_tag[k-1];
                r_or[k]  <= r_or[k-1];
                r_cx[k]  <= r_cx[k-1];
                r_cy[k]  <= r_cy[k-1];
            end
            for (int k = 1; k <= NST; k++) begin
                // zero edges stay zero: y=0 path would still turn, so hold
                r_a[k] <= (r_a[k-1].x == 0 && r_a[k-1].y == 0) ? r_a[k-1]
                          : cord_step(r_a[k-1], k-1);
                r_b[k] <= (r_b[k-1].x == 0 && r_b[k-1].y == 0) ? r_b[k-1]
                          : cord_step(r_b[k-1], k-1);
                r_p[k] <= sq_step(r_p[k-1], k-1);
                r_q[k] <= sq_step(r_q[k-1], k-1);
            end
            // stage NST+1: wrap of difference, diagonal mean
            r_a01 <= r_a[NST].z;
            r_ch  <= wrapz((ZW+2)'(r_b[NST].z) - (ZW+2)'(r_a[NST].z));
            r_dl  <= 17'((20'(r_p[NST].r) + 20'(r_q[NST].r) + 20'd4) >> 3);
            // stage NST+2: half the difference onto the bottom edge
            r_tw  <= ZW'(wrapz((ZW+2)'(r_a01) + (r_ch >>> 1)));
            r_dl2 <= r_dl;
            r_out.tag_out         <= r_tag[NST+2];
            r_out.orientation_out <= r_or[NST+2];
            r_out.mid_x           <= r_cx[NST+2];
            r_out.mid_y           <= r_cy[NST+2];
            r_out.diagonal_len    <= r_dl2;
            r_out.twist_angle     <= round13(r_tw);
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;
endmodule

[rtl/qtpm_checker.sv]
`timescale 1ns / 1ps
`include "quad_tag_pose_measure_core_defines.svh"
module qtpm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input qtpm_pkg::t_out_word o_data
);
    import qtpm_pkg::*;
    `QTPM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
    `QTPM_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall, i_valid)
    `QTPM_ASSERT_IMP(a_twist_range, i_clk, i_rst_n, o_valid, o_data.twist_angle != PI_Q13)
    `QTPM_ASSERT_IMP(a_diag_range, i_clk, i_rst_n, o_valid, o_data.diagonal_len <= 17'd92682)
endmodule

bind quad_tag_pose_measure_core qtpm_checker u_chk (
    .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall, .o_data
);

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
    import qtpm_pkg::*;

    localparam int         CORDIC_STEPS = 16;
    localparam longint     PI_Q30_L     = 64'sd3373259426;
    localparam longint     PI_Q13_L     = 64'sd25736;
    localparam longint     EDGE_SCALE   = 64'sd16777216;
    localparam int         STALL_LIMIT  = 3000;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         DRAIN_CYCLES = 40;

    // corner rotation per orientation code
    localparam int unsigned ORIENT_SHIFT [4] = '{2, 1, 0, 3};

    localparam longint ATAN_TAB [24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_word  i_data  = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_word o_data;

    t_out_word pose_q[$];
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    bit        hold_req      = 1'b0;
    int        hold_left     = 0;
    int        err_cnt       = 0;
    int        words_in      = 0;
    int        words_out     = 0;
    int        quiet_cycles  = 0;

    quad_tag_pose_measure_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint wrap_angle(longint v);
        while (v >= PI_Q30_L) v -= 2 * PI_Q30_L;
        while (v < -PI_Q30_L) v += 2 * PI_Q30_L;
        return v;
    endfunction

    // vectoring CORDIC, angle in Q.30
    function automatic longint edge_angle(longint dy, longint dx);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        z = 0;
        if (dx == 0 && dy == 0) return 0;
        x = dx * EDGE_SCALE;
        y = dy * EDGE_SCALE;
        if (x < 0) begin
            z = (y >= 0) ? PI_Q30_L : -PI_Q30_L;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TAB[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TAB[i];
            end
        end
        return z;
    endfunction

    function automatic longint unsigned diag_root(longint dx, longint dy);
        longint unsigned v;
        longint unsigned r;
        longint unsigned b;
        v = longint'(dx * dx + dy * dy) << 4;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_out_word predict_pose(t_in_word w);
        longint    rx [4];
        longint    ry [4];
        longint    px [4];
        longint    py [4];
        longint    a01;
        longint    a32;
        longint    tw;
        longint    t13;
        longint unsigned dsum;
        int unsigned src;
        t_out_word p;
        rx[0] = w.corner0_x; ry[0] = w.corner0_y;
        rx[1] = w.corner1_x; ry[1] = w.corner1_y;
        rx[2] = w.corner2_x; ry[2] = w.corner2_y;
        rx[3] = w.corner3_x; ry[3] = w.corner3_y;
        for (int k = 0; k < 4; k++) begin
            src = (3 - k + ORIENT_SHIFT[w.orientation]) & 3;
            px[k] = rx[src];
            py[k] = ry[src];
        end
        a01 = edge_angle(py[0] - py[1], px[0] - px[1]);
        a32 = edge_angle(py[3] - py[2], px[3] - px[2]);
        tw  = wrap_angle(a01 + (wrap_angle(a32 - a01) >>> 1));
        t13 = (tw + 65536) >>> 17;
        if (t13 >= PI_Q13_L) t13 -= 2 * PI_Q13_L;
        dsum = diag_root(px[0] - px[2], py[0] - py[2])
             + diag_root(px[1] - px[3], py[1] - py[3]) + 4;
        p.tag_out         = w.tag_id;
        p.orientation_out = w.orientation;
        p.mid_x           = 18'(px[0] + px[1] + px[2] + px[3]);
        p.mid_y           = 18'(py[0] + py[1] + py[2] + py[3]);
        p.diagonal_len    = 17'(dsum >> 3);
        p.twist_angle     = 16'(t13);
        return p;
    endfunction

    // holds the word until the block takes it; valid stays high on return
    task automatic send_word(t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pose_q.push_back(predict_pose(w));
        words_in++;
    endtask

    function automatic t_in_word make_quad(int unsigned tag, int unsigned ori,
                                           int cx, int cy, int a, int b);
        t_in_word w;
        w.tag_id      = 16'(tag);
        w.orientation = 2'(ori);
        w.corner0_x = 16'(cx + a);  w.corner0_y = 16'(cy + b);
        w.corner1_x = 16'(cx - b);  w.corner1_y = 16'(cy + a);
        w.corner2_x = 16'(cx - a);  w.corner2_y = 16'(cy - b);
        w.corner3_x = 16'(cx + b);  w.corner3_y = 16'(cy - a);
        return w;
    endfunction

    function automatic t_in_word rand_word();
        t_in_word w;
        int r;
        if ($urandom_range(99) < 75) begin
            r = $urandom_range(2000, 1);
            w = make_quad($urandom_range(65535), $urandom_range(3),
                          $urandom_range(63000, 2500), $urandom_range(63000, 2500),
                          $urandom_range(2 * r) - r, $urandom_range(2 * r) - r);
        end else begin
            w = {18'($urandom), $urandom, $urandom, $urandom, $urandom};
        end
        return w;
    endfunction

    task automatic test_directed();
        t_in_word w;
        send_word('0);
        send_word('1);
        for (int o = 0; o < 4; o++)
            send_word(make_quad(16'h1234 + o, o, 30000, 20000, 400, 150));
        // zero-length edges: corners coincide pairwise
        w = '0;
        w.corner0_x = 16'd100; w.corner1_x = 16'd100;
        w.corner2_x = 16'd900; w.corner3_x = 16'd900;
        w.corner0_y = 16'd200; w.corner1_y = 16'd200;
        w.corner2_y = 16'd700; w.corner3_y = 16'd700;
        send_word(w);
        // all corners on one point
        w = {16'hBEEF, 2'd3, {4{16'd4321, 16'd8765}}};
        send_word(w);
        // edges with negative dx, with dy positive and negative
        send_word(make_quad(7, 2, 32768, 32768, -1000, 0));
        send_word(make_quad(8, 2, 32768, 32768, -1000, 1));
        send_word(make_quad(9, 2, 32768, 32768, -1000, -1));
        send_word(make_quad(10, 0, 32768, 32768, 0, 1000));
        // widest spread of coordinates
        w = {16'h8001, 2'd1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
             16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        send_word(w);
        w = {16'h7FFE, 2'd2, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
             16'hFFFF, 16'h0000, 16'h0000, 16'h0000};
        send_word(w);
        w = {16'hAAAA, 2'd0, {8{16'h5555}}};
        send_word(w);
        w = {16'h5555, 2'd3, {4{16'hAAAA, 16'h5555}}};
        send_word(w);
    endtask

    task automatic test_random(int s_pct, int r_pct, int n);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < n; i++) send_word(rand_word());
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++) send_word(rand_word());
    endtask

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_valid && !i_stall) begin
            words_out++;
            if (pose_q.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, o_data);
                err_cnt++;
            end else begin
                e = pose_q.pop_front();
                if (o_data.tag_out !== e.tag_out) begin
                    $display("%0t: tag_out exp %h act %h", $time, e.tag_out, o_data.tag_out);
                    err_cnt++;
                end
                if (o_data.orientation_out !== e.orientation_out) begin
                    $display("%0t: orientation_out exp %0d act %0d", $time,
                             e.orientation_out, o_data.orientation_out);
                    err_cnt++;
                end
                if (o_data.mid_x !== e.mid_x) begin
                    $display("%0t: mid_x exp %0d act %0d", $time, e.mid_x, o_data.mid_x);
                    err_cnt++;
                end
                if (o_data.mid_y !== e.mid_y) begin
                    $display("%0t: mid_y exp %0d act %0d", $time, e.mid_y, o_data.mid_y);
                    err_cnt++;
                end
                if (o_data.diagonal_len !== e.diagonal_len) begin
                    $display("%0t: diagonal_len exp %0d act %0d", $time,
                             e.diagonal_len, o_data.diagonal_len);
                    err_cnt++;
                end
                if (o_data.twist_angle !== e.twist_angle) begin
                    $display("%0t: twist_angle exp %0d act %0d", $time,
                             e.twist_angle, o_data.twist_angle);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired, %0d words outstanding", $time, pose_q.size());
            $display("quad_tag_pose_measure_core test failed");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(14, 67, 120);
        test_random(67, 14, 120);
        test_random(0, 0, 120);
        test_backpressure();
        i_valid <= 1'b0;
        recv_idle_pct = 0;
        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d words (directed corners, random squares and noise),", words_in);
        $display("checked %0d results under idling, stalls and a long back-pressure hold.",
                 words_out);
        if (err_cnt == 0 && pose_q.size() == 0)
            $display("quad_tag_pose_measure_core test passed");
        else
            $display("quad_tag_pose_measure_core test failed");
        $finish;
    end
endmodule
